// ----- rtl/spc_pkg.sv -----
package spc_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KLEN_W = $clog2(KEY_DEPTH + 1);
  localparam int PERM_DEPTH = 256;
  localparam int APB_AW = 3;

  localparam logic REG_STRIDE = 1'b0;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] wdata;
  } perm_req_t;

  typedef struct packed {
    logic              we;
    logic [KEY_AW-1:0] addr;
    logic [7:0]        wdata;
  } key_req_t;

  typedef struct packed {
    logic [7:0] stride;
  } cfg_t;

endpackage

// ----- rtl/spc_in_if.sv -----
interface spc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] value;
  logic       final_key;

  modport source (output valid, output op, output value, output final_key, input ready);
  modport sink (input valid, input op, input value, input final_key, output ready);
endinterface

// ----- rtl/spc_out_if.sv -----
interface spc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_out;

  modport source (output valid, output cipher_out, input ready);
  modport sink (input valid, input cipher_out, output ready);
endinterface

// ----- rtl/spc_ram.sv -----
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/spc_cfg.sv -----
module spc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output spc_pkg::cfg_t              cfg
);

  logic [7:0] stride;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= 8'd1;
    end else if (wr_en && paddr[2] == spc_pkg::REG_STRIDE) begin
      stride <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == spc_pkg::REG_STRIDE) begin
      prdata = {24'd0, stride};
    end
  end

  assign cfg.stride = stride | 8'd1;

endmodule

// ----- rtl/spc_engine.sv -----
module spc_engine (
  input  logic                clk,
  input  logic                rst,
  input  spc_pkg::cfg_t       cfg,
  spc_in_if.sink              din,
  spc_out_if.source           dout,
  output spc_pkg::perm_req_t  perm_req,
  input  logic [7:0]          perm_rdata,
  output spc_pkg::key_req_t   key_req,
  input  logic [7:0]          key_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_KINIT, S_KRD, S_KSUM, S_KW1, S_KW2,
    S_DRI, S_DRJ, S_DRK, S_DW1, S_DW2, S_DZ1, S_DZ2, S_DZ3, S_DOUT, S_DSEND
  } state_t;

  state_t                     state;
  logic [7:0]                 idx_i;
  logic [7:0]                 idx_j;
  logic [7:0]                 idx_k;
  logic [7:0]                 prev_draw;
  logic [spc_pkg::KLEN_W-1:0] key_len;
  logic [7:0]                 n;
  logic [7:0]                 jj;
  logic [spc_pkg::KEY_AW-1:0] kidx;
  logic [7:0]                 held;
  logic [7:0]                 data_val;
  logic [7:0]                 res;
  logic                       out_valid;
  logic [7:0]                 out_data;

  logic                       accept;
  logic                       key_room;
  logic [spc_pkg::KLEN_W-1:0] key_len_next;
  logic [7:0]                 jj_next;
  logic [7:0]                 result;
  logic                       out_free;
  logic                       out_load;

  assign din.ready = (state == S_IDLE);
  assign accept = din.valid & din.ready;
  assign key_room = key_len < spc_pkg::KLEN_W'(spc_pkg::KEY_DEPTH);
  assign key_len_next = key_room ? key_len + spc_pkg::KLEN_W'(1) : key_len;
  assign jj_next = jj + perm_rdata + key_rdata;
  assign result = data_val ^ perm_rdata;
  assign out_free = !out_valid || dout.ready;
  assign out_load = ((state == S_DOUT) || (state == S_DSEND)) && out_free;

  assign dout.valid = out_valid;
  assign dout.cipher_out = out_data;

  always_comb begin
    perm_req = '0;
    unique case (state)
      S_KINIT: begin
        perm_req.we = 1'b1;
        perm_req.addr = n;
        perm_req.wdata = n;
      end
      S_KRD: perm_req.addr = n;
      S_KSUM: perm_req.addr = jj_next;
      S_KW1: begin
        perm_req.we = 1'b1;
        perm_req.addr = n;
        perm_req.wdata = perm_rdata;
      end
      S_KW2: begin
        perm_req.we = 1'b1;
        perm_req.addr = jj;
        perm_req.wdata = held;
      end
      S_DRI: perm_req.addr = idx_i;
      S_DRJ: perm_req.addr = idx_j + perm_rdata;
      S_DRK: perm_req.addr = idx_k + perm_rdata;
      S_DW1: begin
        perm_req.we = 1'b1;
        perm_req.addr = idx_i;
        perm_req.wdata = perm_rdata;
      end
      S_DW2: begin
        perm_req.we = 1'b1;
        perm_req.addr = idx_j;
        perm_req.wdata = held;
      end
      S_DZ1: perm_req.addr = prev_draw + idx_k;
      S_DZ2: perm_req.addr = idx_i + perm_rdata;
      S_DZ3: perm_req.addr = idx_j + perm_rdata;
      default: perm_req = '0;
    endcase
  end

  always_comb begin
    key_req.we = 1'b0;
    key_req.addr = kidx;
    key_req.wdata = din.value;
    if (state == S_IDLE) begin
      key_req.we = accept && din.op == spc_pkg::OP_KEY && key_room;
      key_req.addr = key_len[spc_pkg::KEY_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx_i <= 8'd0;
      idx_j <= 8'd0;
      idx_k <= 8'd0;
      prev_draw <= 8'd0;
      key_len <= '0;
      n <= 8'd0;
      jj <= 8'd0;
      kidx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (din.op == spc_pkg::OP_KEY) begin
              key_len <= key_len_next;
              if (din.final_key) begin
                n <= 8'd0;
                state <= S_KINIT;
              end
            end else begin
              idx_i <= idx_i + cfg.stride;
              data_val <= din.value;
              state <= S_DRI;
            end
          end
        end
        S_KINIT: begin
          n <= n + 8'd1;
          if (n == 8'd255) begin
            jj <= 8'd0;
            kidx <= '0;
            state <= S_KRD;
          end
        end
        S_KRD: state <= S_KSUM;
        S_KSUM: begin
          jj <= jj_next;
          held <= perm_rdata;
          state <= S_KW1;
        end
        S_KW1: state <= S_KW2;
        S_KW2: begin
          n <= n + 8'd1;
          if (spc_pkg::KLEN_W'(kidx) + spc_pkg::KLEN_W'(1) == key_len) begin
            kidx <= '0;
          end else begin
            kidx <= kidx + spc_pkg::KEY_AW'(1);
          end
          if (n == 8'd255) begin
            idx_i <= 8'd0;
            idx_j <= 8'd0;
            idx_k <= 8'd0;
            prev_draw <= 8'd0;
            key_len <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_KRD;
          end
        end
        S_DRI: state <= S_DRJ;
        S_DRJ: begin
          held <= perm_rdata;
          state <= S_DRK;
        end
        S_DRK: begin
          idx_j <= idx_k + perm_rdata;
          state <= S_DW1;
        end
        S_DW1: begin
          idx_k <= idx_i + idx_k + perm_rdata;
          state <= S_DW2;
        end
        S_DW2: state <= S_DZ1;
        S_DZ1: state <= S_DZ2;
        S_DZ2: state <= S_DZ3;
        S_DZ3: state <= S_DOUT;
        S_DOUT: begin
          prev_draw <= perm_rdata;
          res <= result;
          if (out_free) begin
            out_data <= result;
            state <= S_IDLE;
          end else begin
            state <= S_DSEND;
          end
        end
        S_DSEND: begin
          if (out_free) begin
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/spritz_stream_cipher.sv -----
// data word: DRI, DRJ, DRK, DW1, DW2, DZ1, DZ2, DZ3 each make one permutation-port access
// key word: stored if the key store has room; a final one starts 256 fill writes (KINIT),
// then 256 swap steps (KRD, KSUM, KW1, KW2); a new word is taken only back in IDLE
// reset: synchronous, clears indices, key count, output valid; stride returns to 1
// permutation and key store contents are not cleared by reset
module spritz_stream_cipher (
  input  logic                       clk,
  input  logic                       rst,
  spc_in_if.sink                     din,
  spc_out_if.source                  dout,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  spc_pkg::cfg_t      cfg;
  spc_pkg::perm_req_t perm_req;
  spc_pkg::key_req_t  key_req;
  logic [7:0]         perm_rdata;
  logic [7:0]         key_rdata;

  spc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spc_ram #(
    .WIDTH (8),
    .DEPTH (spc_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm_req.we),
    .addr  (perm_req.addr),
    .wdata (perm_req.wdata),
    .rdata (perm_rdata)
  );

  spc_ram #(
    .WIDTH (8),
    .DEPTH (spc_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_req.we),
    .addr  (key_req.addr),
    .wdata (key_req.wdata),
    .rdata (key_rdata)
  );

  spc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .din        (din),
    .dout       (dout),
    .perm_req   (perm_req),
    .perm_rdata (perm_rdata),
    .key_req    (key_req),
    .key_rdata  (key_rdata)
  );

endmodule

// ----- bench/tb_spritz_stream_cipher.sv -----
`timescale 1ns / 100ps

module tb_spritz_stream_cipher;

  localparam logic [spc_pkg::APB_AW-1:0] STRIDE_ADDR =
    spc_pkg::APB_AW'(4 * spc_pkg::REG_STRIDE);
  localparam int SETTLE_CYCLES = 1400;
  localparam int WORD_BUDGET = 1050;
  localparam int QUIET_AFTER = 900;

  class spritz_tracker;
    logic [7:0]  perm [spc_pkg::PERM_DEPTH];
    logic [7:0]  key_bytes [spc_pkg::KEY_DEPTH];
    int unsigned key_count;
    logic [7:0]  i_idx;
    logic [7:0]  j_idx;
    logic [7:0]  k_idx;
    logic [7:0]  last_z;
    logic [7:0]  step;
    logic [7:0]  expected_bytes [$];
    int          errors;
    int          checked;

    function new();
      key_count = 0;
      i_idx = 8'd0;
      j_idx = 8'd0;
      k_idx = 8'd0;
      last_z = 8'd0;
      step = 8'd1;
      errors = 0;
      checked = 0;
    endfunction

    function void absorb(input logic op, input logic [7:0] val, input logic fin);
      int         len;
      logic [7:0] jj;
      logic [7:0] t;
      logic [7:0] w;
      logic [7:0] z;
      if (op == spc_pkg::OP_KEY) begin
        if (key_count < spc_pkg::KEY_DEPTH) begin
          key_bytes[key_count] = val;
          key_count++;
        end
        if (fin) begin
          len = (key_count == 0 || key_count > spc_pkg::KEY_DEPTH) ?
                spc_pkg::KEY_DEPTH : key_count;
          for (int n = 0; n < spc_pkg::PERM_DEPTH; n++) perm[n] = 8'(n);
          jj = 8'd0;
          for (int n = 0; n < spc_pkg::PERM_DEPTH; n++) begin
            jj = 8'(jj + perm[n] + key_bytes[n % len]);
            t = perm[n];
            perm[n] = perm[jj];
            perm[jj] = t;
          end
          i_idx = 8'd0;
          j_idx = 8'd0;
          k_idx = 8'd0;
          last_z = 8'd0;
          key_count = 0;
        end
      end else begin
        w = step | 8'd1;
        i_idx = 8'(i_idx + w);
        j_idx = 8'(k_idx + perm[8'(j_idx + perm[i_idx])]);
        k_idx = 8'(i_idx + k_idx + perm[j_idx]);
        t = perm[i_idx];
        perm[i_idx] = perm[j_idx];
        perm[j_idx] = t;
        z = perm[8'(last_z + k_idx)];
        z = perm[8'(i_idx + z)];
        z = perm[8'(j_idx + z)];
        last_z = z;
        expected_bytes.push_back(val ^ z);
      end
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_byte(input logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("cipher_out %02h with no word pending", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report($sformatf("cipher_out word %0d: got %02h, want %02h", checked, got, want));
        checked++;
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [spc_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spc_in_if  din_bus ();
  spc_out_if dout_bus ();

  spritz_tracker keystream;
  int sent_words;
  int gap_odds;
  int stall_odds;
  bit quiet;

  spritz_stream_cipher u_top (
    .clk     (clk),
    .rst     (rst),
    .din     (din_bus),
    .dout    (dout_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(input logic op, input logic [7:0] val, input logic fin);
    if (!quiet && gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
      din_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    din_bus.valid <= 1'b1;
    din_bus.op <= op;
    din_bus.value <= val;
    din_bus.final_key <= fin;
    do @(posedge clk); while (din_bus.ready !== 1'b1);
    keystream.absorb(op, val, fin);
    sent_words++;
    quiet = (sent_words >= QUIET_AFTER);
  endtask

  task automatic load_key(input int len, input bit close);
    for (int n = 0; n < len; n++)
      send_word(spc_pkg::OP_KEY, 8'($urandom_range(0, 255)), close && (n == len - 1));
  endtask

  task automatic send_data(input int count);
    for (int n = 0; n < count; n++)
      send_word(spc_pkg::OP_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_and_settle();
    din_bus.valid <= 1'b0;
    while (keystream.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STRIDE_ADDR;
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    keystream.step = val;
  endtask

  always @(posedge clk) begin
    if (!rst && dout_bus.valid === 1'b1 && dout_bus.ready === 1'b1)
      keystream.check_byte(dout_bus.cipher_out);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
        dout_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        dout_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] stride_plan [6];
    int         phase;
    int         phase_end;
    int         pick;
    bit         long_pending;
    stride_plan = '{8'd255, 8'd1, 8'd2, 8'd128, 8'd85, 8'd170};
    keystream = new();
    sent_words = 0;
    quiet = 1'b0;
    gap_odds = 3;
    stall_odds = 2;
    rst = 1'b1;
    din_bus.valid = 1'b0;
    din_bus.op = spc_pkg::OP_KEY;
    din_bus.value = 8'd0;
    din_bus.final_key = 1'b0;
    dout_bus.ready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one zero byte as the whole key
    send_word(spc_pkg::OP_KEY, 8'h00, 1'b1);
    send_word(spc_pkg::OP_DATA, 8'h00, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'hFF, 1'b1);
    send_word(spc_pkg::OP_DATA, 8'h5A, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'hFF, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'h00, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'h80, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'h01, 1'b1);
    send_word(spc_pkg::OP_DATA, 8'h00, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'hFF, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'h81, 1'b1);
    send_word(spc_pkg::OP_DATA, 8'h7E, 1'b0);
    drain_and_settle();
    // even stride, low bit forced
    write_stride(8'hFE);
    send_word(spc_pkg::OP_DATA, 8'h00, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'hFF, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'h3C, 1'b1);
    // key bytes split by data, key keeps growing
    send_word(spc_pkg::OP_KEY, 8'h01, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'h02, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'h11, 1'b0);
    send_word(spc_pkg::OP_KEY, 8'h03, 1'b1);
    send_word(spc_pkg::OP_DATA, 8'hC3, 1'b0);
    send_word(spc_pkg::OP_DATA, 8'h24, 1'b0);

    phase = 0;
    long_pending = 1'b1;
    while (sent_words < WORD_BUDGET) begin
      drain_and_settle();
      write_stride(phase < 6 ? stride_plan[phase] : 8'($urandom_range(1, 255)));
      gap_odds = $urandom_range(0, 6);
      stall_odds = $urandom_range(0, 6);
      phase_end = sent_words + 150;
      while (sent_words < phase_end && sent_words < WORD_BUDGET) begin
        pick = $urandom_range(0, 99);
        if (long_pending || pick < 2) begin
          // key of 255 to 266 bytes; bytes past the key store depth, possibly the final one, are dropped
          load_key($urandom_range(255, 266), 1'b1);
          send_data($urandom_range(1, 30));
          long_pending = 1'b0;
        end else if (pick < 75) begin
          load_key($urandom_range(1, 16), 1'b1);
          send_data($urandom_range(1, 40));
        end else if (pick < 88) begin
          load_key($urandom_range(1, 6), 1'b0);
          send_data($urandom_range(1, 8));
        end else begin
          send_data($urandom_range(1, 12));
        end
      end
      phase++;
    end
    drain_and_settle();

    if (keystream.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spc_pkg.sv
rtl/spc_in_if.sv
rtl/spc_out_if.sv
rtl/spc_ram.sv
rtl/spc_cfg.sv
rtl/spc_engine.sv
rtl/spritz_stream_cipher.sv
bench/tb_spritz_stream_cipher.sv
